// File: rtl/core/khf_pkg.sv
// Package for the key hasher: hash constants, queue sizing and shared types.
package khf_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned LEN_SHIFT = 56;
  localparam int unsigned MIX_SHIFT = 33;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = QAW + 1;

  typedef logic [63:0] word64_t;

  typedef struct packed {
    logic empty;
    logic full;
  } khf_qstat_t;

  // Low 64 bits of x * 0x100000001b3 as shifts and adds.
  function automatic word64_t fnv_mul(input word64_t x);
    word64_t s0;
    word64_t s1;
    word64_t s2;
    begin
      s0 = x + (x << 1);
      s1 = (x << 4) + (x << 5);
      s2 = (x << 7) + (x << 8);
      fnv_mul = (s0 + s1) + (s2 + (x << 40));
    end
  endfunction

  function automatic word64_t xor_shr(input word64_t x);
    xor_shr = x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

// File: rtl/core/khf_front.sv
// Front end: per-byte FNV-1a step, short key packing, length count, pre-mix word.
module khf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_key_byte,
  input  logic               in_last_byte,
  input  khf_pkg::khf_qstat_t q_stat,
  output logic               push,
  output khf_pkg::word64_t   push_data
);
  import khf_pkg::*;

  word64_t    fnv_r, fnv_nxt;
  word64_t    packed_r, packed_nxt;
  logic [7:0] len_r, len_nxt;
  logic       longer_r, longer_nxt;

  logic       accept;
  word64_t    fnv_step;
  word64_t    packed_step;
  logic [7:0] len_step;
  logic       longer_step;
  word64_t    sel;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    fnv_step    = fnv_mul(fnv_r ^ {56'b0, in_key_byte});
    len_step    = len_r + 8'd1;
    longer_step = longer_r || (len_r >= 8'd8);
    packed_step = packed_r;
    if (!longer_r && len_r < 8'd8) begin
      packed_step = packed_r | ({56'b0, in_key_byte} << {len_r[2:0], 3'b000});
    end
    sel       = longer_step ? fnv_step : packed_step;
    push_data = sel ^ ({56'b0, len_step} << LEN_SHIFT);
    push      = accept && in_last_byte;

    fnv_nxt    = fnv_r;
    packed_nxt = packed_r;
    len_nxt    = len_r;
    longer_nxt = longer_r;
    if (accept) begin
      if (in_last_byte) begin
        fnv_nxt    = FNV_BASIS;
        packed_nxt = '0;
        len_nxt    = '0;
        longer_nxt = 1'b0;
      end else begin
        fnv_nxt    = fnv_step;
        packed_nxt = packed_step;
        len_nxt    = len_step;
        longer_nxt = longer_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fnv_r    <= FNV_BASIS;
      packed_r <= '0;
      len_r    <= '0;
      longer_r <= 1'b0;
    end else begin
      fnv_r    <= fnv_nxt;
      packed_r <= packed_nxt;
      len_r    <= len_nxt;
      longer_r <= longer_nxt;
    end
  end

endmodule

// File: rtl/core/khf_queue.sv
// Short queue of pre-mix words between the front end and the finalizer.
module khf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  khf_pkg::word64_t    push_data,
  input  logic                pop,
  output khf_pkg::word64_t    pop_data,
  output khf_pkg::khf_qstat_t q_stat
);
  import khf_pkg::*;

  word64_t        mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCW'(QDEPTH));
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("queue count out of range");

endmodule

// File: rtl/core/khf_back.sv
// Back end: fmix64 finalizer on one shared 32x32 multiplier, with output register.
module khf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  khf_pkg::khf_qstat_t q_stat,
  input  khf_pkg::word64_t    pop_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         out_hash_value
);
  import khf_pkg::*;

  typedef enum logic {ST_IDLE, ST_MUL} state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        second_r, second_nxt;
  word64_t     h_r, h_nxt;
  word64_t     acc_r, acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  word64_t     out_hash_r, out_hash_nxt;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  word64_t     mconst;
  word64_t     res;
  word64_t     fin;
  logic        can_emit;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign can_emit       = !out_valid_r || !out_stall;
  assign pop            = (state_r == ST_IDLE) && !q_stat.empty;

  // low 64 bits of h * c: lo*lo, then the two cross terms into the upper half
  always_comb begin
    mconst = second_r ? MIX_C2 : MIX_C1;
    case (cnt_r)
      2'd0:    begin mul_a = h_r[31:0];  mul_b = mconst[31:0];  end
      2'd1:    begin mul_a = h_r[31:0];  mul_b = mconst[63:32]; end
      default: begin mul_a = h_r[63:32]; mul_b = mconst[31:0];  end
    endcase
    prod = mul_a * mul_b;
    res  = acc_r + {prod[31:0], 32'b0};
    fin  = xor_shr(res);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    second_nxt    = second_r;
    h_nxt         = h_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hash_nxt  = out_hash_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          h_nxt      = xor_shr(pop_data);
          cnt_nxt    = 2'd0;
          second_nxt = 1'b0;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_r == 2'd0) begin
          acc_nxt = prod;
          cnt_nxt = 2'd1;
        end else if (cnt_r == 2'd1) begin
          acc_nxt = res;
          cnt_nxt = 2'd2;
        end else if (!second_r) begin
          h_nxt      = fin;
          second_nxt = 1'b1;
          cnt_nxt    = 2'd0;
        end else if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = fin;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 2'd0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
    h_r        <= h_nxt;
    acc_r      <= acc_nxt;
    out_hash_r <= out_hash_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> cnt_r != 2'd3)
    else $error("multiply step counter out of range");

  a_emit_after_second: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_MUL && $past(second_r))
    else $error("hash emitted before second multiply finished");

  a_start_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && !q_stat.empty |=> state_r == ST_MUL && cnt_r == 2'd0)
    else $error("finalizer did not start on queued word");

endmodule

// File: rtl/core/key_hash_fnv1a_fmix64.sv
// Top level of the streaming key hasher: front end, word queue and finalizer.
// Key bytes enter one per cycle on in_ while the queue has room; the front end keeps an
// FNV-1a accumulator, a packing of the first eight bytes and the length, and on the last
// byte pushes the pre-mix word into a four-entry queue. The finalizer runs fmix64 on one
// shared 32x32 multiplier: a load step, then each 64-bit multiply as the lo*lo product
// and the two cross terms. It takes the next queued word only once it is back in idle,
// while the front end keeps taking bytes as long as the queue has room. The hash is
// registered on out_ and held while out_stall is high. No clearing pass follows reset.
module key_hash_fnv1a_fmix64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);
  import khf_pkg::*;

  khf_qstat_t q_stat;
  logic       push;
  word64_t    push_data;
  logic       pop;
  word64_t    pop_data;

  khf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  khf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  khf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop_data       (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule
